// ----- rtl/core/olds_pkg.sv -----
`timescale 1ns / 1ps

package olds_pkg;

	localparam int DATA_W       = 32;
	localparam int POS_W        = 4;
	localparam int CNT_OUT_W    = 5;
	localparam int CMD_W        = 2;
	localparam int STAT_W       = 2;
	localparam int DEF_CAPACITY = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_INS_FRONT = 2'd0,
		CMD_INS_REAR  = 2'd1,
		CMD_DELETE    = 2'd2,
		CMD_SEARCH    = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_POS   = 2'd1,
		STAT_FULL      = 2'd2,
		STAT_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic {
		OLDS_IDLE,
		OLDS_SCAN
	} state_t;

	// list-wide operation broadcast to every cell
	typedef enum logic [2:0] {
		MODE_HOLD,
		MODE_FRONT,
		MODE_REAR,
		MODE_DEL,
		MODE_ROT
	} mode_t;

	// per-cell source select
	typedef enum logic [2:0] {
		MV_HOLD,
		MV_LOAD,
		MV_LEFT,
		MV_RIGHT,
		MV_WRAP
	} mv_t;

endpackage

// ----- rtl/core/olds_cell.sv -----
`timescale 1ns / 1ps

module olds_cell (
	input  logic                              clk,
	input  olds_pkg::mv_t                     mv,
	input  logic [olds_pkg::DATA_W-1:0]       load_val,
	input  logic [olds_pkg::DATA_W-1:0]       prev_val,
	input  logic [olds_pkg::DATA_W-1:0]       next_val,
	input  logic [olds_pkg::DATA_W-1:0]       head_val,
	output logic [olds_pkg::DATA_W-1:0]       val
);

	logic [olds_pkg::DATA_W-1:0] val_q;

	always_ff @(posedge clk) begin
		case (mv)
			olds_pkg::MV_HOLD:  val_q <= val_q;
			olds_pkg::MV_LOAD:  val_q <= load_val;
			olds_pkg::MV_LEFT:  val_q <= prev_val;
			olds_pkg::MV_RIGHT: val_q <= next_val;
			olds_pkg::MV_WRAP:  val_q <= head_val;
			default:            val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

// ----- rtl/core/ordered_list_deque_search.sv -----
`timescale 1ns / 1ps

// channel | dir | handshake         | payload
// s_*     | in  | s_tvalid/s_tready | s_tuser: cmd; s_tdata: data_value, position
// m_*     | out | m_tvalid/m_tready | m_tuser: status;
//         |     |                   | m_tdata: result_value, found_position, entry_count
//
// Insert and delete finish in the cycle the beat is taken: every cell picks its
// neighbor, the input word or itself at once. Search rotates the occupied part of
// the ring past cell 0 once, comparing each entry with the key as it passes.
// Reset clears the entry count and control; cell contents stay until written.
// A beat is taken while idle and the two-deep result buffer has a free slot.

module ordered_list_deque_search #(
	parameter int CAPACITY = olds_pkg::DEF_CAPACITY
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // [31:0] data_value, [35:32] position
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // [31:0] result_value, [35:32] found_position,
	                               // [40:36] entry_count
	output logic [1:0]  m_tuser    // [1:0] status
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > olds_pkg::POS_W) ? CW : olds_pkg::POS_W;
	localparam int DW = olds_pkg::DATA_W;

	olds_pkg::state_t state_q, state_d;
	olds_pkg::mode_t  mode;
	olds_pkg::cmd_t   cmd;

	logic [DW-1:0]               in_val;
	logic [olds_pkg::POS_W-1:0]  in_pos;
	logic                        accept;

	logic [CW-1:0] count_q, count_d, cnt_m1;
	logic [IW-1:0] step_q, fpos_q;
	logic          hit_q;
	logic [DW-1:0] key_q;
	logic          head_hit, full, pos_ok;

	logic [DW-1:0] cell_val [CAPACITY];
	olds_pkg::mv_t cell_mv  [CAPACITY];

	logic                   done;
	olds_pkg::status_t      res_status;
	logic [DW-1:0]          res_val;
	logic [IW-1:0]          res_fpos;
	logic [47:0]            res_data;

	logic        out_v_q, skid_v_q, pop;
	logic [47:0] out_data_q, skid_data_q;
	logic [1:0]  out_user_q, skid_user_q;

	assign cmd    = olds_pkg::cmd_t'(s_tuser[1:0]);
	assign in_val = s_tdata[DW-1:0];
	assign in_pos = s_tdata[35:32];

	assign s_tready = (state_q == olds_pkg::OLDS_IDLE) && !skid_v_q;
	assign accept   = s_tvalid && s_tready;

	assign cnt_m1   = count_q - 1'b1;
	assign full     = (count_q == CW'(CAPACITY));
	assign pos_ok   = (PW'(in_pos) < PW'(count_q));
	assign head_hit = (cell_val[0] == key_q);

	always_comb begin
		state_d    = state_q;
		mode       = olds_pkg::MODE_HOLD;
		count_d    = count_q;
		done       = 1'b0;
		res_status = olds_pkg::STAT_OK;
		res_val    = '0;
		res_fpos   = '0;
		case (state_q)
			olds_pkg::OLDS_IDLE: begin
				if (accept) begin
					case (cmd)
						olds_pkg::CMD_INS_FRONT, olds_pkg::CMD_INS_REAR: begin
							done = 1'b1;
							if (full) begin
								res_status = olds_pkg::STAT_FULL;
							end else begin
								mode    = (cmd == olds_pkg::CMD_INS_FRONT) ?
								          olds_pkg::MODE_FRONT : olds_pkg::MODE_REAR;
								count_d = count_q + 1'b1;
							end
						end
						olds_pkg::CMD_DELETE: begin
							done = 1'b1;
							if (pos_ok) begin
								mode    = olds_pkg::MODE_DEL;
								res_val = cell_val[IW'(in_pos)];
								count_d = cnt_m1;
							end else begin
								res_status = olds_pkg::STAT_BAD_POS;
							end
						end
						olds_pkg::CMD_SEARCH: begin
							if (count_q == '0) begin
								done       = 1'b1;
								res_status = olds_pkg::STAT_NOT_FOUND;
							end else begin
								state_d = olds_pkg::OLDS_SCAN;
							end
						end
						default: ;
					endcase
				end
			end
			olds_pkg::OLDS_SCAN: begin
				mode = olds_pkg::MODE_ROT;
				if (step_q == IW'(cnt_m1)) begin
					done    = 1'b1;
					state_d = olds_pkg::OLDS_IDLE;
					if (hit_q) begin
						res_fpos = fpos_q;
					end else if (head_hit) begin
						res_fpos = step_q;
					end else begin
						res_status = olds_pkg::STAT_NOT_FOUND;
					end
				end
			end
			default: state_d = olds_pkg::OLDS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= olds_pkg::OLDS_IDLE;
			count_q <= '0;
			hit_q   <= 1'b0;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == olds_pkg::OLDS_IDLE) begin
				step_q <= '0;
				hit_q  <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
				if (head_hit && !hit_q) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= in_val;
		end
		if (state_q == olds_pkg::OLDS_SCAN && head_hit && !hit_q) begin
			fpos_q <= step_q;
		end
	end

	// cell row: each cell derives its source from the broadcast mode
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DW-1:0] prev_val, next_val;

		if (i == 0) begin : g_first
			assign prev_val = in_val;
		end else begin : g_mid
			assign prev_val = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_val = cell_val[0];
		end else begin : g_inner
			assign next_val = cell_val[i+1];
		end

		always_comb begin
			cell_mv[i] = olds_pkg::MV_HOLD;
			case (mode)
				olds_pkg::MODE_FRONT: begin
					if (i == 0) begin
						cell_mv[i] = olds_pkg::MV_LOAD;
					end else if (CW'(i) <= count_q) begin
						cell_mv[i] = olds_pkg::MV_LEFT;
					end
				end
				olds_pkg::MODE_REAR: begin
					if (CW'(i) == count_q) begin
						cell_mv[i] = olds_pkg::MV_LOAD;
					end
				end
				olds_pkg::MODE_DEL: begin
					if (PW'(i) >= PW'(in_pos) && CW'(i) < cnt_m1) begin
						cell_mv[i] = olds_pkg::MV_RIGHT;
					end
				end
				olds_pkg::MODE_ROT: begin
					if (CW'(i) < cnt_m1) begin
						cell_mv[i] = olds_pkg::MV_RIGHT;
					end else if (CW'(i) == cnt_m1) begin
						cell_mv[i] = olds_pkg::MV_WRAP;
					end
				end
				default: cell_mv[i] = olds_pkg::MV_HOLD;
			endcase
		end

		olds_cell u_cell (
			.clk      (clk),
			.mv       (cell_mv[i]),
			.load_val (in_val),
			.prev_val (prev_val),
			.next_val (next_val),
			.head_val (cell_val[0]),
			.val      (cell_val[i])
		);
	end

	assign res_data = {7'd0, 5'(count_d), 4'(res_fpos), res_val};

	// two-deep result buffer
	assign pop = out_v_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (skid_v_q) begin
				if (pop) begin
					skid_v_q <= 1'b0;
				end
			end else if (done) begin
				if (out_v_q && !pop) begin
					skid_v_q <= 1'b1;
				end else begin
					out_v_q <= 1'b1;
				end
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end
		end else if (done) begin
			if (out_v_q && !pop) begin
				skid_data_q <= res_data;
				skid_user_q <= res_status;
			end else begin
				out_data_q <= res_data;
				out_user_q <= res_status;
			end
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule
